// File: rtl/core/tpmt_pkg.sv
// shared codes for the text position marker table
// request modes and result status values; no dependencies
package tpmt_pkg;

    localparam logic [2:0] MODE_GET    = 3'd0;
    localparam logic [2:0] MODE_UNREF  = 3'd1;
    localparam logic [2:0] MODE_QUERY  = 3'd2;
    localparam logic [2:0] MODE_INSERT = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BADH  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    localparam int REFS_W = 16;

endpackage

// File: rtl/core/tpmt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tpmt_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// File: rtl/core/text_position_marker_table.sv
// text position marker table: reference-counted markers kept in one ram
// depends on tpmt_pkg and tpmt_ram
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request: get, unref,
//   query, insert text or delete text. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result per request, in order.
//   Every marker entry lives in one ram word {used, ok, refs, pos}.
//   Get, insert of a nonzero amount and delete of a nonempty range walk the
//   whole table through the ram, one entry a cycle, read-modify-write with
//   the write in the cycle after the read. Requests are taken one at a time.
//   After reset a clearing pass writes every entry, during which no request
//   is taken.
//   A finished result waits in the output register while the next request
//   is taken; if the receiver stalls, the next result waits in its final
//   state until the output register is free.
module text_position_marker_table #(
    parameter int MARKER_SLOTS = 64,
    parameter int POS_BITS     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_position,
    input  logic [31:0] i_amount,
    input  logic [31:0] i_range_end,
    input  logic [5:0]  i_handle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_marker_id,
    output logic [31:0] o_marker_pos,
    output logic        o_marker_valid,
    output logic [1:0]  o_status
);
    import tpmt_pkg::*;

    localparam int IW = $clog2(MARKER_SLOTS);
    localparam int CW = IW + 1;
    localparam int WW = POS_BITS + REFS_W + 2;
    localparam int SW = POS_BITS + 33;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_GETWR = 3'd3;
    localparam logic [2:0] S_HWAIT = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [IW-1:0]     LAST_IDX = IW'(MARKER_SLOTS - 1);
    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    function automatic logic [31:0] pos_to32(input logic [POS_BITS-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[31:0];
    endfunction

    function automatic logic [5:0] idx_to_id(input logic [IW-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[5:0];
    endfunction

    // control registers
    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_addr, n_addr;
    logic        r_rd_v, n_rd_v;
    logic        r_out_v, n_out_v;

    // request and search payload
    logic [IW-1:0]       r_rd_idx;
    logic [2:0]          r_mode;
    logic [POS_BITS-1:0] r_pos, r_rend, r_len;
    logic [31:0]         r_amt;
    logic [IW-1:0]       r_hidx;
    logic [5:0]          r_handle;
    logic                r_fm, r_ff;
    logic [IW-1:0]       r_midx, r_fidx;
    logic [POS_BITS-1:0] r_mpos;
    logic                r_mok;
    logic [REFS_W-1:0]   r_mrefs;
    logic [5:0]          r_p_id;
    logic [31:0]         r_p_pos;
    logic                r_p_val;
    logic [1:0]          r_p_st;
    logic [5:0]          r_o_id;
    logic [31:0]         r_o_pos;
    logic                r_o_val;
    logic [1:0]          r_o_st;

    // ram
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0] ram_wdata, ram_rdata;

    logic                q_used, q_ok;
    logic [REFS_W-1:0]   q_refs;
    logic [POS_BITS-1:0] q_pos;

    logic [63:0]         pos64, rend64;
    logic [31:0]         hx;
    logic [POS_BITS-1:0] in_pos, in_rend;
    logic                acc, h_bad, issue, sweep_last, emit_load;
    logic [SW-1:0]       ins_sum;
    logic [POS_BITS-1:0] ins_pos;
    logic                ins_hit, del_in, del_after, get_match;
    logic [REFS_W-1:0]   refs_dec;

    assign q_used = ram_rdata[WW-1];
    assign q_ok   = ram_rdata[WW-2];
    assign q_refs = ram_rdata[WW-3 -: REFS_W];
    assign q_pos  = ram_rdata[POS_BITS-1:0];

    assign pos64   = 64'(i_position);
    assign rend64  = 64'(i_range_end);
    assign in_pos  = pos64[POS_BITS-1:0];
    assign in_rend = rend64[POS_BITS-1:0];
    assign hx      = 32'(i_handle);
    assign h_bad   = hx >= 32'(MARKER_SLOTS);

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    assign issue      = (r_state == S_SWEEP) && (r_addr < CW'(MARKER_SLOTS));
    assign sweep_last = r_rd_v && (r_rd_idx == LAST_IDX);
    assign emit_load  = (r_state == S_EMIT) && (!r_out_v || i_out_ready);

    // per-entry work during the table walk
    assign ins_sum   = SW'(q_pos) + SW'(r_amt);
    assign ins_pos   = (ins_sum[SW-1:POS_BITS] != '0) ? '1 : ins_sum[POS_BITS-1:0];
    assign ins_hit   = q_used && (q_pos >= r_pos);
    assign del_in    = q_used && (q_pos >= r_pos) && (q_pos < r_rend);
    assign del_after = q_used && (q_pos >= r_rend);
    assign get_match = q_used && (q_pos == r_pos);
    assign refs_dec  = (q_refs == '0) ? '0 : q_refs - REFS_W'(1);

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_addr[IW-1:0];
        if (issue) begin
            ram_re = 1'b1;
        end else if (acc && (i_mode == MODE_UNREF || i_mode == MODE_QUERY)) begin
            ram_re    = !h_bad;
            ram_raddr = hx[IW-1:0];
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rd_idx;
        ram_wdata = {1'b1, q_ok, q_refs, q_pos};
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[IW-1:0];
                ram_wdata = '0;
            end
            S_SWEEP: begin
                if (r_rd_v && r_mode == MODE_INSERT && ins_hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, q_ok, q_refs, ins_pos};
                end else if (r_rd_v && r_mode == MODE_DELETE && del_in) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, 1'b0, q_refs, r_pos};
                end else if (r_rd_v && r_mode == MODE_DELETE && del_after) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, q_ok, q_refs, q_pos - r_len};
                end
            end
            S_GETWR: begin
                if (r_fm) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_midx;
                    ram_wdata = {1'b1, r_mok,
                                 (r_mrefs == REFS_MAX) ? r_mrefs : r_mrefs + REFS_W'(1),
                                 r_mpos};
                end else if (r_ff) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_fidx;
                    ram_wdata = {1'b1, 1'b1, REFS_W'(1), r_pos};
                end
            end
            S_HWAIT: begin
                // release: the entry goes free once the count reaches zero
                if (r_mode == MODE_UNREF && q_used) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_hidx;
                    ram_wdata = {refs_dec != '0, q_ok, refs_dec, q_pos};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_rd_v  = issue;
        n_out_v = emit_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_v);
        unique case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + CW'(1);
                if (r_addr[IW-1:0] == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_addr  = '0;
                    n_state = S_EMIT;
                    unique case (i_mode)
                        MODE_GET: n_state = S_SWEEP;
                        MODE_UNREF, MODE_QUERY: begin
                            if (!h_bad) n_state = S_HWAIT;
                        end
                        MODE_INSERT: begin
                            if (i_amount != '0) n_state = S_SWEEP;
                        end
                        MODE_DELETE: begin
                            if (in_pos < in_rend) n_state = S_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                if (issue) n_addr = r_addr + CW'(1);
                if (sweep_last) n_state = (r_mode == MODE_GET) ? S_GETWR : S_EMIT;
            end
            S_GETWR: n_state = S_EMIT;
            S_HWAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (emit_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_rd_v  <= n_rd_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[IW-1:0];
        if (acc) begin
            r_mode   <= i_mode;
            r_pos    <= in_pos;
            r_rend   <= in_rend;
            r_len    <= in_rend - in_pos;
            r_amt    <= i_amount;
            r_hidx   <= hx[IW-1:0];
            r_handle <= i_handle;
            r_fm     <= 1'b0;
            r_ff     <= 1'b0;
            unique case (i_mode)
                MODE_UNREF, MODE_QUERY: begin
                    r_p_id  <= i_handle;
                    r_p_pos <= '0;
                    r_p_val <= 1'b0;
                    r_p_st  <= ST_BADH;
                end
                MODE_INSERT, MODE_DELETE: begin
                    r_p_id  <= '0;
                    r_p_pos <= pos_to32(in_pos);
                    r_p_val <= 1'b0;
                    r_p_st  <= (i_mode == MODE_DELETE && in_pos > in_rend) ? ST_ORDER : ST_OK;
                end
                default: begin
                    r_p_id  <= '0;
                    r_p_pos <= '0;
                    r_p_val <= 1'b0;
                    r_p_st  <= ST_OK;
                end
            endcase
        end
        // lowest matching and lowest free entry seen so far
        if (r_state == S_SWEEP && r_rd_v && r_mode == MODE_GET) begin
            if (get_match && !r_fm) begin
                r_fm    <= 1'b1;
                r_midx  <= r_rd_idx;
                r_mpos  <= q_pos;
                r_mok   <= q_ok;
                r_mrefs <= q_refs;
            end
            if (!q_used && !r_ff) begin
                r_ff   <= 1'b1;
                r_fidx <= r_rd_idx;
            end
        end
        if (r_state == S_GETWR) begin
            priority if (r_fm) begin
                r_p_id  <= idx_to_id(r_midx);
                r_p_pos <= pos_to32(r_mpos);
                r_p_val <= r_mok;
                r_p_st  <= ST_OK;
            end else if (r_ff) begin
                r_p_id  <= idx_to_id(r_fidx);
                r_p_pos <= pos_to32(r_pos);
                r_p_val <= 1'b1;
                r_p_st  <= ST_OK;
            end else begin
                r_p_id  <= '0;
                r_p_pos <= '0;
                r_p_val <= 1'b0;
                r_p_st  <= ST_FULL;
            end
        end
        if (r_state == S_HWAIT && q_used) begin
            r_p_id  <= r_handle;
            r_p_pos <= pos_to32(q_pos);
            r_p_val <= q_ok;
            r_p_st  <= ST_OK;
        end
        if (emit_load) begin
            r_o_id  <= r_p_id;
            r_o_pos <= r_p_pos;
            r_o_val <= r_p_val;
            r_o_st  <= r_p_st;
        end
    end

    tpmt_ram #(
        .WIDTH (WW),
        .DEPTH (MARKER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_out_v;
    assign o_marker_id    = r_o_id;
    assign o_marker_pos   = r_o_pos;
    assign o_marker_valid = r_o_val;
    assign o_status       = r_o_st;
endmodule

// File: rtl/core/tpmt_checker.sv
// port-level checks for the text position marker table
// depends on tpmt_pkg; bound to text_position_marker_table
module tpmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_marker_id,
    input logic [31:0] o_marker_pos,
    input logic        o_marker_valid,
    input logic [1:0]  o_status
);
    import tpmt_pkg::*;

    // a result stays offered until the receiver takes it
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    // one request at a time: ready drops after every transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |->
            o_marker_id == 6'd0 && o_marker_pos == 32'd0 && !o_marker_valid)
        else $error("table full result not cleared");

    a_badh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_BADH |-> o_marker_pos == 32'd0 && !o_marker_valid)
        else $error("bad handle result carries data");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_ORDER |-> o_marker_id == 6'd0 && !o_marker_valid)
        else $error("delete order result carries marker");
endmodule

bind text_position_marker_table tpmt_checker u_tpmt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_marker_id    (o_marker_id),
    .o_marker_pos   (o_marker_pos),
    .o_marker_valid (o_marker_valid),
    .o_status       (o_status)
);
